[rtl/core/cbiw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbiw_pkg
// Shared types and codes of the CBOR item walker: head event kinds, fault
// codes, level flag bits and the event record passed from front to back.
// ----------------------------------------------------------------------------
package cbiw_pkg;

    // what the back end does with a head event
    localparam logic [2:0] KIND_NONE  = 3'd0;  // report only, no stack change
    localparam logic [2:0] KIND_ELEM  = 3'd1;  // one element finished
    localparam logic [2:0] KIND_CONT  = 3'd2;  // array or map head
    localparam logic [2:0] KIND_BREAK = 3'd3;  // break outside an indefinite string
    localparam logic [2:0] KIND_FAULT = 3'd4;  // fault found by the front end
    localparam logic [2:0] KIND_PEND  = 3'd5;  // last payload byte of a definite string

    // fault codes
    localparam logic [2:0] FAULT_NONE     = 3'd0;
    localparam logic [2:0] FAULT_INVALID  = 3'd1;
    localparam logic [2:0] FAULT_OVERFLOW = 3'd2;
    localparam logic [2:0] FAULT_CHUNK    = 3'd3;
    localparam logic [2:0] FAULT_BREAK    = 3'd4;
    localparam logic [2:0] FAULT_DEEP     = 3'd5;

    // major types
    localparam logic [2:0] MAJ_UINT   = 3'd0;
    localparam logic [2:0] MAJ_NINT   = 3'd1;
    localparam logic [2:0] MAJ_BYTES  = 3'd2;
    localparam logic [2:0] MAJ_TEXT   = 3'd3;
    localparam logic [2:0] MAJ_ARRAY  = 3'd4;
    localparam logic [2:0] MAJ_MAP    = 3'd5;
    localparam logic [2:0] MAJ_TAG    = 3'd6;
    localparam logic [2:0] MAJ_SIMPLE = 3'd7;

    // minor codes
    localparam logic [4:0] MIN_IMM_MAX = 5'd23;
    localparam logic [4:0] MIN_ARG1    = 5'd24;
    localparam logic [4:0] MIN_ARG2    = 5'd25;
    localparam logic [4:0] MIN_ARG4    = 5'd26;
    localparam logic [4:0] MIN_ARG8    = 5'd27;
    localparam logic [4:0] MIN_INDEF   = 5'd31;

    // level flag bits
    localparam int FL_INDEF = 0;
    localparam int FL_MAP   = 1;
    localparam int FL_VALUE = 2;

    // one completed head, or the end of a definite string
    typedef struct packed {
        logic        start;
        logic [2:0]  kind;
        logic [2:0]  major;
        logic [4:0]  minor;
        logic [63:0] arg;
        logic [2:0]  fault;
    } head_ev_t;

endpackage

[rtl/core/cbiw_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbiw_front
// Byte level parser: splits heads, gathers arguments, skips string payload,
// checks indefinite string chunks and classifies each head for the back end.
// ----------------------------------------------------------------------------
module cbiw_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          byte_value,
    input  logic                start_item,
    output logic                ev_push,
    output cbiw_pkg::head_ev_t  ev
);

    localparam logic [1:0] PH_HEAD    = 2'd0;
    localparam logic [1:0] PH_ARG     = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_HALT    = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  left_reg, left_next;
    logic [63:0] accum_reg, accum_next;
    logic [2:0]  maj_reg, maj_next;
    logic [4:0]  min_reg, min_next;
    logic [30:0] pl_reg, pl_next;
    logic [2:0]  indef_reg, indef_next;
    logic        spend_reg, spend_next;

    // per-byte parse and head classification
    always_comb
    begin
        logic [1:0]  ph;
        logic [2:0]  ind;
        logic        fin;
        logic [2:0]  fm;
        logic [4:0]  fn;
        logic [63:0] fa;
        logic [63:0] len;
        logic        invalid;
        logic        brk;
        logic [2:0]  kind;
        logic [2:0]  flt;
        ph         = start_item ? PH_HEAD : phase_reg;
        ind        = start_item ? 3'd0 : indef_reg;
        fin        = 1'b0;
        fm         = maj_reg;
        fn         = min_reg;
        fa         = accum_reg;
        len        = 64'd0;
        invalid    = 1'b0;
        brk        = 1'b0;
        kind       = cbiw_pkg::KIND_NONE;
        flt        = cbiw_pkg::FAULT_NONE;
        phase_next = phase_reg;
        left_next  = left_reg;
        accum_next = accum_reg;
        maj_next   = maj_reg;
        min_next   = min_reg;
        pl_next    = pl_reg;
        indef_next = indef_reg;
        spend_next = spend_reg;
        ev_push    = 1'b0;
        ev         = '0;

        if (accept)
        begin
            spend_next = spend_reg | start_item;
            phase_next = ph;
            indef_next = ind;
            case (ph)
                PH_HEAD:
                begin
                    fm       = byte_value[7:5];
                    fn       = byte_value[4:0];
                    maj_next = fm;
                    min_next = fn;
                    if (fn <= cbiw_pkg::MIN_IMM_MAX)
                    begin
                        fa         = {59'd0, fn};
                        accum_next = fa;
                        fin        = 1'b1;
                    end
                    else if (fn <= cbiw_pkg::MIN_ARG8)
                    begin
                        accum_next = 64'd0;
                        phase_next = PH_ARG;
                        case (fn)
                            cbiw_pkg::MIN_ARG1: left_next = 4'd1;
                            cbiw_pkg::MIN_ARG2: left_next = 4'd2;
                            cbiw_pkg::MIN_ARG4: left_next = 4'd4;
                            default:            left_next = 4'd8;
                        endcase
                    end
                    else
                    begin
                        fa         = 64'd0;
                        accum_next = fa;
                        fin        = 1'b1;
                    end
                end
                PH_ARG:
                begin
                    fa         = {accum_reg[55:0], byte_value};
                    accum_next = fa;
                    left_next  = left_reg - 4'd1;
                    if (left_reg == 4'd1)
                    begin
                        fin = 1'b1;
                    end
                end
                PH_PAYLOAD:
                begin
                    pl_next = pl_reg - 31'd1;
                    if (pl_reg == 31'd1)
                    begin
                        phase_next = PH_HEAD;
                        if (ind == 3'd0)
                        begin
                            ev_push    = 1'b1;
                            ev.kind    = cbiw_pkg::KIND_PEND;
                            ev.major   = maj_reg;
                            ev.minor   = min_reg;
                            ev.arg     = accum_reg;
                            ev.fault   = cbiw_pkg::FAULT_NONE;
                            ev.start   = spend_reg | start_item;
                            spend_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            // head complete: classify
            if (fin)
            begin
                phase_next = PH_HEAD;
                brk        = (fm == cbiw_pkg::MAJ_SIMPLE) && (fn == cbiw_pkg::MIN_INDEF);
                invalid    = (fn >= 5'd28 && fn <= 5'd30) ||
                             (fn == cbiw_pkg::MIN_INDEF &&
                              (fm == cbiw_pkg::MAJ_UINT || fm == cbiw_pkg::MAJ_NINT ||
                               fm == cbiw_pkg::MAJ_TAG));
                if (invalid)
                begin
                    flt = cbiw_pkg::FAULT_INVALID;
                end
                else if (ind != 3'd0)
                begin
                    // inside an indefinite string
                    if (brk)
                    begin
                        indef_next = 3'd0;
                        kind       = cbiw_pkg::KIND_ELEM;
                    end
                    else if (fm != ind)
                    begin
                        flt = cbiw_pkg::FAULT_CHUNK;
                    end
                    else
                    begin
                        len = (fn == cbiw_pkg::MIN_INDEF) ? 64'd0 : fa;
                        if (|len[63:31])
                        begin
                            flt = cbiw_pkg::FAULT_OVERFLOW;
                        end
                        else if (len != 64'd0)
                        begin
                            pl_next    = len[30:0];
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                else
                begin
                    case (fm)
                        cbiw_pkg::MAJ_UINT, cbiw_pkg::MAJ_NINT:
                        begin
                            kind = cbiw_pkg::KIND_ELEM;
                        end
                        cbiw_pkg::MAJ_TAG:
                        begin
                            kind = cbiw_pkg::KIND_NONE;
                        end
                        cbiw_pkg::MAJ_BYTES, cbiw_pkg::MAJ_TEXT:
                        begin
                            if (fn == cbiw_pkg::MIN_INDEF)
                            begin
                                indef_next = fm;
                            end
                            else if (|fa[63:31])
                            begin
                                flt = cbiw_pkg::FAULT_OVERFLOW;
                            end
                            else if (fa != 64'd0)
                            begin
                                pl_next    = fa[30:0];
                                phase_next = PH_PAYLOAD;
                            end
                            else
                            begin
                                kind = cbiw_pkg::KIND_ELEM;
                            end
                        end
                        cbiw_pkg::MAJ_ARRAY, cbiw_pkg::MAJ_MAP:
                        begin
                            kind = cbiw_pkg::KIND_CONT;
                        end
                        default:
                        begin
                            kind = brk ? cbiw_pkg::KIND_BREAK : cbiw_pkg::KIND_ELEM;
                        end
                    endcase
                end
                if (flt != cbiw_pkg::FAULT_NONE)
                begin
                    kind       = cbiw_pkg::KIND_FAULT;
                    phase_next = PH_HALT;
                end
                ev_push    = 1'b1;
                ev.kind    = kind;
                ev.major   = fm;
                ev.minor   = fn;
                ev.arg     = fa;
                ev.fault   = flt;
                ev.start   = spend_reg | start_item;
                spend_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEAD;
            left_reg  <= 4'd0;
            indef_reg <= 3'd0;
            spend_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            indef_reg <= indef_next;
            spend_reg <= spend_next;
        end
    end

    // head payload
    always_ff @(posedge clk)
    begin
        accum_reg <= accum_next;
        maj_reg   <= maj_next;
        min_reg   <= min_next;
        pl_reg    <= pl_next;
    end

endmodule

[rtl/core/cbiw_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbiw_queue
// Two entry queue of head events between the front and back ends.
// ----------------------------------------------------------------------------
module cbiw_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cbiw_pkg::head_ev_t  push_ev,
    output logic                full,
    output logic                not_empty,
    input  logic                pop,
    output cbiw_pkg::head_ev_t  head
);

    cbiw_pkg::head_ev_t slot_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = slot_reg[rd_reg];

    // pointer and fill count
    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_ev;
        end
    end

endmodule

[rtl/core/cbiw_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbiw_back
// Nesting stack and result register: applies head events to the level
// stack, closes any number of levels at once and reports each head.
// ----------------------------------------------------------------------------
module cbiw_back
#(
    parameter int MAX_DEPTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [4:0]          depth_limit,
    input  logic                ev_valid,
    input  cbiw_pkg::head_ev_t  ev,
    output logic                ev_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          major_kind,
    output logic [4:0]          minor_code,
    output logic [63:0]         argument,
    output logic [4:0]          nesting,
    output logic [2:0]          fault,
    output logic                item_done
);

    localparam int LW = $clog2(MAX_DEPTH + 1);
    localparam int CW = (LW > 5) ? LW : 5;

    logic [LW-1:0]        lc_reg, lc_next;
    logic                 halt_reg, halt_next;
    logic                 ov_reg, ov_next;
    logic [63:0]          rem_reg [MAX_DEPTH];
    logic [2:0]           flg_reg [MAX_DEPTH];
    logic [MAX_DEPTH-1:0] last_reg;

    logic [LW-1:0]        lc_eff;
    logic                 act;
    logic                 emit;
    logic                 do_push;
    logic [2:0]           push_flg;
    logic                 do_cas;
    logic [LW-1:0]        cas_base;
    logic [MAX_DEPTH:0]   chain;
    logic [LW-1:0]        new_lc;
    logic [2:0]           flt;
    logic                 done;
    logic [4:0]           nest;

    assign ev_pop = ev_valid && (!ov_reg || !out_stall);

    // event decode and cascaded close
    always_comb
    begin
        logic [CW-1:0] lim;
        logic          top_indef;
        logic          ok;
        lc_eff    = ev.start ? '0 : lc_reg;
        act       = ev.start || !halt_reg;
        lim       = (CW'(depth_limit) < CW'(MAX_DEPTH)) ? CW'(depth_limit) : CW'(MAX_DEPTH);
        top_indef = 1'b0;
        for (int i = 0; i < MAX_DEPTH; i++)
        begin
            if (LW'(i + 1) == lc_eff)
            begin
                top_indef = flg_reg[i][cbiw_pkg::FL_INDEF];
            end
        end

        emit     = act;
        do_push  = 1'b0;
        push_flg = 3'd0;
        do_cas   = 1'b0;
        cas_base = lc_eff;
        flt      = cbiw_pkg::FAULT_NONE;
        nest     = 5'(lc_eff);
        case (ev.kind)
            cbiw_pkg::KIND_ELEM:
            begin
                do_cas = 1'b1;
            end
            cbiw_pkg::KIND_CONT:
            begin
                push_flg = {1'b0, ev.major == cbiw_pkg::MAJ_MAP, 1'b0};
                if (CW'(lc_eff) >= lim)
                begin
                    flt = cbiw_pkg::FAULT_DEEP;
                end
                else if (ev.minor == cbiw_pkg::MIN_INDEF)
                begin
                    do_push  = 1'b1;
                    push_flg[cbiw_pkg::FL_INDEF] = 1'b1;
                end
                else if (ev.arg == 64'd0)
                begin
                    do_cas = 1'b1;
                end
                else
                begin
                    do_push = 1'b1;
                end
            end
            cbiw_pkg::KIND_BREAK:
            begin
                if (lc_eff != '0 && top_indef)
                begin
                    do_cas   = 1'b1;
                    cas_base = lc_eff - LW'(1);
                end
                else
                begin
                    flt = cbiw_pkg::FAULT_BREAK;
                end
            end
            cbiw_pkg::KIND_FAULT:
            begin
                flt = ev.fault;
            end
            cbiw_pkg::KIND_PEND:
            begin
                do_cas = 1'b1;
                nest   = 5'd0;
            end
            default:
            begin
            end
        endcase

        // a level closes when it is definite, not waiting for a map value
        // and on its last element
        chain[MAX_DEPTH] = 1'b1;
        for (int i = MAX_DEPTH - 1; i >= 0; i--)
        begin
            ok = !flg_reg[i][cbiw_pkg::FL_INDEF] &&
                 (!flg_reg[i][cbiw_pkg::FL_MAP] || flg_reg[i][cbiw_pkg::FL_VALUE]) &&
                 last_reg[i];
            chain[i] = (LW'(i) >= cas_base) || (ok && chain[i + 1]);
        end
        new_lc = '0;
        for (int i = 1; i <= MAX_DEPTH; i++)
        begin
            if (chain[i] && !chain[i - 1])
            begin
                new_lc = LW'(i);
            end
        end

        done = do_cas && chain[0] && (flt == cbiw_pkg::FAULT_NONE);
        if (ev.kind == cbiw_pkg::KIND_PEND)
        begin
            emit = act && chain[0];
        end

        lc_next   = lc_reg;
        halt_next = halt_reg;
        if (ev_pop)
        begin
            halt_next = !act || (flt != cbiw_pkg::FAULT_NONE);
            if (!act)
            begin
                lc_next = lc_eff;
            end
            else if (do_push)
            begin
                lc_next = lc_eff + LW'(1);
            end
            else if (do_cas)
            begin
                lc_next = new_lc;
            end
            else
            begin
                lc_next = lc_eff;
            end
        end
        ov_next = (ov_reg && out_stall) || (ev_pop && emit);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg   <= '0;
            halt_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            lc_reg   <= lc_next;
            halt_reg <= halt_next;
            ov_reg   <= ov_next;
        end
    end

    // level stack, each entry updated at its own place
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_DEPTH; i++)
        begin
            if (ev_pop && act)
            begin
                if (do_push && LW'(i) == lc_eff)
                begin
                    flg_reg[i]  <= push_flg;
                    rem_reg[i]  <= push_flg[cbiw_pkg::FL_INDEF] ? 64'd0 : ev.arg;
                    last_reg[i] <= !push_flg[cbiw_pkg::FL_INDEF] && (ev.arg == 64'd1);
                end
                else if (do_cas && !chain[0] && LW'(i + 1) == new_lc)
                begin
                    if (flg_reg[i][cbiw_pkg::FL_INDEF])
                    begin
                        flg_reg[i] <= flg_reg[i];
                    end
                    else if (flg_reg[i][cbiw_pkg::FL_MAP] && !flg_reg[i][cbiw_pkg::FL_VALUE])
                    begin
                        flg_reg[i][cbiw_pkg::FL_VALUE] <= 1'b1;
                    end
                    else
                    begin
                        flg_reg[i][cbiw_pkg::FL_VALUE] <= 1'b0;
                        rem_reg[i]  <= rem_reg[i] - 64'd1;
                        last_reg[i] <= (rem_reg[i] == 64'd2);
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ev_pop && emit)
        begin
            major_kind <= ev.major;
            minor_code <= ev.minor;
            argument   <= ev.arg;
            nesting    <= nest;
            fault      <= flt;
            item_done  <= done;
        end
    end

    assign out_valid = ov_reg;

endmodule

[rtl/core/cbor_item_walker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbor_item_walker
// Streaming CBOR item walker, reading its input one stream byte at a time.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle while in_stall is low. A head's result
// passes through a queue slot and then the result register before it shows
// on the output, as long as no earlier result is being held by out_stall. A
// held result lets the two entry queue fill, and then raises in_stall. The
// front end parses bytes and classifies each completed head. The queue
// carries head events to the back end. The back end's level stack closes any
// number of levels at once from per-level last-element flags, so each event
// retires as it is popped. A result is given for each completed head, and
// when the last payload byte of a definite string ends the top-level item. The
// first fault is reported, then bytes are ignored until start_item. depth_limit
// may be written only while the walker is idle.
module cbor_item_walker
#(
    parameter int MAX_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_value,
    input  logic        start_item,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  major_kind,
    output logic [4:0]  minor_code,
    output logic [63:0] argument,
    output logic [4:0]  nesting,
    output logic [2:0]  fault,
    output logic        item_done
);

    logic [4:0]         depth_limit_reg, depth_limit_next;
    logic               q_full;
    logic               q_ne;
    logic               q_pop;
    logic               f_push;
    cbiw_pkg::head_ev_t f_ev;
    cbiw_pkg::head_ev_t q_head;

    // configuration register
    assign cfg_ready = 1'b1;
    assign depth_limit_next = (cfg_valid && cfg_ready) ? cfg_data : depth_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_limit_reg <= 5'd16;
        end
        else
        begin
            depth_limit_reg <= depth_limit_next;
        end
    end

    assign in_stall = q_full;

    cbiw_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_valid && !in_stall),
        .byte_value (byte_value),
        .start_item (start_item),
        .ev_push    (f_push),
        .ev         (f_ev)
    );

    cbiw_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_ev   (f_ev),
        .full      (q_full),
        .not_empty (q_ne),
        .pop       (q_pop),
        .head      (q_head)
    );

    cbiw_back #(.MAX_DEPTH(MAX_DEPTH)) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .depth_limit (depth_limit_reg),
        .ev_valid    (q_ne),
        .ev          (q_head),
        .ev_pop      (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .major_kind  (major_kind),
        .minor_code  (minor_code),
        .argument    (argument),
        .nesting     (nesting),
        .fault       (fault),
        .item_done   (item_done)
    );

endmodule

[rtl/core/cbiw_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbiw_checker
// Port level checks of the CBOR item walker, bound to the top level.
// ----------------------------------------------------------------------------
module cbiw_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  major_kind,
    input  logic [4:0]  minor_code,
    input  logic [63:0] argument,
    input  logic [2:0]  fault,
    input  logic        item_done
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(argument) && $stable(fault))
    else $error("stalled result changed");

    // a faulting head never completes an item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault != cbiw_pkg::FAULT_NONE |-> !item_done)
    else $error("fault with item done");

    // too deep only on containers
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault == cbiw_pkg::FAULT_DEEP |->
        major_kind == cbiw_pkg::MAJ_ARRAY || major_kind == cbiw_pkg::MAJ_MAP)
    else $error("too deep on a non-container");

    // stray break only on a break head
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault == cbiw_pkg::FAULT_BREAK |->
        major_kind == cbiw_pkg::MAJ_SIMPLE && minor_code == cbiw_pkg::MIN_INDEF)
    else $error("stray break on another head");

    // length overflow only on strings
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault == cbiw_pkg::FAULT_OVERFLOW |->
        major_kind == cbiw_pkg::MAJ_BYTES || major_kind == cbiw_pkg::MAJ_TEXT)
    else $error("overflow on a non-string");

endmodule

bind cbor_item_walker cbiw_checker u_cbiw_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .major_kind (major_kind),
    .minor_code (minor_code),
    .argument   (argument),
    .fault      (fault),
    .item_done  (item_done)
);
